// ----- rtl/core/rpci_pkg.sv -----
// ----------------------------------------------------------------------------
// rpci_pkg
// Shared constants, types and the CORDIC angle table of the partial-cylinder
// ray intersection pipeline.
// ----------------------------------------------------------------------------
package rpci_pkg;

	localparam int FB       = 16;        // fraction bits of positions and distances
	localparam int AB       = 16;        // azimuth bits, 2^AB is one turn
	localparam int ANG_W    = AB + 1;    // azimuth register width (holds one full turn)
	localparam int CORDIC_N = 30;
	localparam int SQRT_N   = 64;
	localparam int DIV_N    = 63;        // quotient bits of the distance divider
	localparam int NDIV_N   = 16;        // quotient bits of the normal dividers
	localparam int CW       = 36;        // CORDIC datapath width

	localparam logic [DIV_N-1:0] T_CAP = DIV_N'(1) << (DIV_N - 1);

	localparam logic [2:0] REG_BOTTOM_Y  = 3'd0;
	localparam logic [2:0] REG_TOP_Y     = 3'd1;
	localparam logic [2:0] REG_RADIUS    = 3'd2;
	localparam logic [2:0] REG_ANGLE_MIN = 3'd3;
	localparam logic [2:0] REG_ANGLE_MAX = 3'd4;
	localparam logic [2:0] REG_MIN_DIST  = 3'd5;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} ray_t;

	typedef struct packed {
		ray_t        ray;
		logic        ok;
		logic        hneg;
		logic [63:0] hmag;
		logic [63:0] a;
	} setup_t;

	typedef struct packed {
		ray_t        ray;
		logic [63:0] a;
		logic        near_ok;
		logic        far_ok;
		logic [64:0] near_num;
		logic [64:0] far_num;
	} num_t;

	typedef struct packed {
		logic               ok;
		logic [DIV_N-1:0]   t;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} hit_t;

	typedef struct packed {
		logic signed [31:0] bottom_y;
		logic signed [31:0] top_y;
		logic [30:0]        radius;
		logic [ANG_W-1:0]   angle_min;
		logic [ANG_W-1:0]   angle_max;
		logic [15:0]        min_dist;
	} cfg_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] turn_atan(input int i);
		case (i)
			0:  return 32'd536870912;
			1:  return 32'd316933406;
			2:  return 32'd167458907;
			3:  return 32'd85004756;
			4:  return 32'd42667331;
			5:  return 32'd21354465;
			6:  return 32'd10679838;
			7:  return 32'd5340245;
			8:  return 32'd2670163;
			9:  return 32'd1335087;
			10: return 32'd667544;
			11: return 32'd333772;
			12: return 32'd166886;
			13: return 32'd83443;
			14: return 32'd41722;
			15: return 32'd20861;
			16: return 32'd10430;
			17: return 32'd5215;
			18: return 32'd2608;
			19: return 32'd1304;
			20: return 32'd652;
			21: return 32'd326;
			22: return 32'd163;
			23: return 32'd81;
			24: return 32'd41;
			25: return 32'd20;
			26: return 32'd10;
			27: return 32'd5;
			28: return 32'd3;
			29: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction

endpackage

// ----- rtl/core/ray_partial_cylinder_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_partial_cylinder_intersect
// Ray against a y-aligned open cylinder cut to a height band and an azimuth
// wedge; returns hit flag, distance, facing normal and hit point.
// ----------------------------------------------------------------------------
// Pipeline: 192 register stages from the start input to done.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 64-stage square root, the 63-stage distance divider, the
// 30-stage azimuth CORDIC and the 16-stage normal dividers.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall: each result shows on done for one cycle only.
module ray_partial_cylinder_intersect import rpci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic               is_hit,
	output logic [30:0]        distance,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_z,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);

	cfg_t   cfg_q;
	ray_t   in_ray;
	logic   setup_vld, sqrt_vld, near_vld, far_vld_unused;
	setup_t setup_side;
	logic [127:0] setup_disc;
	num_t   nums;
	hit_t   near_hit, far_hit, sel_hit;
	ray_t   near_ray;

	// Every request enters the pipeline; nothing holds it off.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign in_ray = '{ox: origin_x, oy: origin_y, oz: origin_z,
	                  dx: dir_x, dy: dir_y, dz: dir_z};

	// Configuration registers: the user must see that they are written only while the
	// pipeline is empty, so every stage reads them live; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bottom_y  <= -(32'sd1 <<< FB);
			cfg_q.top_y     <= 32'sd1 <<< FB;
			cfg_q.radius    <= 31'd1 << FB;
			cfg_q.angle_min <= '0;
			cfg_q.angle_max <= ANG_W'(1) << AB;
			cfg_q.min_dist  <= 16'd7;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOTTOM_Y:  cfg_q.bottom_y  <= $signed(cfg_data);
				REG_TOP_Y:     cfg_q.top_y     <= $signed(cfg_data);
				REG_RADIUS:    cfg_q.radius    <= cfg_data[30:0];
				REG_ANGLE_MIN: cfg_q.angle_min <= cfg_data[ANG_W-1:0];
				REG_ANGLE_MAX: cfg_q.angle_max <= cfg_data[ANG_W-1:0];
				REG_MIN_DIST:  cfg_q.min_dist  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Coefficients h, a, c and the discriminant.
	rpci_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.in_ray   (in_ray),
		.radius   (cfg_q.radius),
		.out_vld  (setup_vld),
		.out_side (setup_side),
		.out_disc (setup_disc)
	);

	// Integer square root and both root numerators.
	rpci_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (setup_vld),
		.in_side (setup_side),
		.in_disc (setup_disc),
		.out_vld (sqrt_vld),
		.out_num (nums)
	);

	// Near and far roots run side by side with identical latency.
	rpci_root u_near (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sqrt_vld),
		.in_ok   (nums.near_ok),
		.in_num  (nums.near_num),
		.in_a    (nums.a),
		.in_ray  (nums.ray),
		.cfg     (cfg_q),
		.out_vld (near_vld),
		.out_hit (near_hit),
		.out_ray (near_ray)
	);

	rpci_root u_far (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sqrt_vld),
		.in_ok   (nums.far_ok),
		.in_num  (nums.far_num),
		.in_a    (nums.a),
		.in_ray  (nums.ray),
		.cfg     (cfg_q),
		.out_vld (far_vld_unused),
		.out_hit (far_hit),
		.out_ray ()
	);

	// Near root wins when accepted; otherwise fall back to the far root.
	assign sel_hit = near_hit.ok ? near_hit : far_hit;

	rpci_normal u_normal (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (near_vld || far_vld_unused),
		.in_hit   (sel_hit),
		.in_dx    (near_ray.dx),
		.in_dz    (near_ray.dz),
		.radius   (cfg_q.radius),
		.out_vld  (done),
		.is_hit   (is_hit),
		.distance (distance),
		.normal_x (normal_x),
		.normal_z (normal_z),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z)
	);

endmodule

// ----- rtl/core/rpci_setup.sv -----
// ----------------------------------------------------------------------------
// rpci_setup
// Quadratic coefficients and discriminant, six register stages.
// ----------------------------------------------------------------------------
module rpci_setup import rpci_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_vld,
	input  ray_t         in_ray,
	input  logic [30:0]  radius,
	output logic         out_vld,
	output setup_t       out_side,
	output logic [127:0] out_disc
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ray_t ray_s1, ray_s2, ray_s3, ray_s4, ray_s5;
	logic signed [63:0] pxx_s1, pzz_s1, dxx_s1, dzz_s1, oxx_s1, ozz_s1;
	logic [61:0] r2_s1, r2_s2;
	logic signed [64:0] h_s2;
	logic [63:0] a_s2, s_s2, a_s3, a_s4, a_s5;
	logic hneg_s3, hneg_s4, hneg_s5, cneg_s3, cneg_s4, cneg_s5;
	logic [63:0] hmag_s3, hmag_s4, hmag_s5, cmag_s3;
	logic [63:0] hp00_s4, hp01_s4, hp11_s4, ap00_s4, ap01_s4, ap10_s4, ap11_s4;
	logic [127:0] hh_s5, ac_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			out_vld <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		// products
		ray_s1 <= in_ray;
		pxx_s1 <= $signed(in_ray.ox) * $signed(in_ray.dx);
		pzz_s1 <= $signed(in_ray.oz) * $signed(in_ray.dz);
		dxx_s1 <= $signed(in_ray.dx) * $signed(in_ray.dx);
		dzz_s1 <= $signed(in_ray.dz) * $signed(in_ray.dz);
		oxx_s1 <= $signed(in_ray.ox) * $signed(in_ray.ox);
		ozz_s1 <= $signed(in_ray.oz) * $signed(in_ray.oz);
		r2_s1  <= radius * radius;
		// sums
		ray_s2 <= ray_s1;
		h_s2   <= pxx_s1 + pzz_s1;
		a_s2   <= dxx_s1[63:0] + dzz_s1[63:0];
		s_s2   <= oxx_s1[63:0] + ozz_s1[63:0];
		r2_s2  <= r2_s1;
		// magnitudes
		ray_s3  <= ray_s2;
		a_s3    <= a_s2;
		hneg_s3 <= h_s2[64];
		hmag_s3 <= h_s2[64] ? 64'(-h_s2) : h_s2[63:0];
		cneg_s3 <= s_s2 < {2'b00, r2_s2};
		cmag_s3 <= (s_s2 < {2'b00, r2_s2}) ? ({2'b00, r2_s2} - s_s2) : (s_s2 - {2'b00, r2_s2});
		// partial products of h^2 and a*c
		ray_s4  <= ray_s3;
		a_s4    <= a_s3;
		hneg_s4 <= hneg_s3;
		hmag_s4 <= hmag_s3;
		cneg_s4 <= cneg_s3;
		hp00_s4 <= hmag_s3[31:0]  * hmag_s3[31:0];
		hp01_s4 <= hmag_s3[31:0]  * hmag_s3[63:32];
		hp11_s4 <= hmag_s3[63:32] * hmag_s3[63:32];
		ap00_s4 <= a_s3[31:0]  * cmag_s3[31:0];
		ap01_s4 <= a_s3[31:0]  * cmag_s3[63:32];
		ap10_s4 <= a_s3[63:32] * cmag_s3[31:0];
		ap11_s4 <= a_s3[63:32] * cmag_s3[63:32];
		// combine partials
		ray_s5  <= ray_s4;
		a_s5    <= a_s4;
		hneg_s5 <= hneg_s4;
		hmag_s5 <= hmag_s4;
		cneg_s5 <= cneg_s4;
		hh_s5   <= {hp11_s4, hp00_s4} + ({64'd0, hp01_s4} << 33);
		ac_s5   <= {ap11_s4, ap00_s4} + ({64'd0, ap01_s4} << 32) + ({64'd0, ap10_s4} << 32);
		// discriminant
		out_disc      <= cneg_s5 ? (hh_s5 + ac_s5) : (hh_s5 - ac_s5);
		out_side.ray  <= ray_s5;
		out_side.a    <= a_s5;
		out_side.hneg <= hneg_s5;
		out_side.hmag <= hmag_s5;
		out_side.ok   <= (a_s5 != 64'd0) && (radius != 31'd0) && (cneg_s5 || (hh_s5 >= ac_s5));
	end

endmodule

// ----- rtl/core/rpci_sqrt.sv -----
// ----------------------------------------------------------------------------
// rpci_sqrt
// Floor square root of the discriminant, one root bit per stage, then the
// numerators of the near and far roots.
// ----------------------------------------------------------------------------
module rpci_sqrt import rpci_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_vld,
	input  setup_t       in_side,
	input  logic [127:0] in_disc,
	output logic         out_vld,
	output num_t         out_num
);

	logic         vld_s  [SQRT_N+1];
	setup_t       side_s [SQRT_N+1];
	logic [127:0] rem_s  [SQRT_N+1];
	logic [63:0]  root_s [SQRT_N+1];
	logic [127:0] trial  [SQRT_N];
	logic         take   [SQRT_N];
	logic [63:0]  root_f;
	setup_t       side_f;

	always_comb begin
		for (int k = 0; k < SQRT_N; k++) begin
			trial[k] = ({64'd0, root_s[k]} << (SQRT_N - k)) | (128'd1 << (2 * (SQRT_N - 1 - k)));
			take[k]  = rem_s[k] >= trial[k];
		end
	end

	assign root_f = root_s[SQRT_N];
	assign side_f = side_s[SQRT_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQRT_N; k++) vld_s[k] <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int k = 0; k < SQRT_N; k++) vld_s[k+1] <= vld_s[k];
			out_vld <= vld_s[SQRT_N];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		rem_s[0]  <= in_disc;
		root_s[0] <= '0;
		for (int k = 0; k < SQRT_N; k++) begin
			side_s[k+1] <= side_s[k];
			rem_s[k+1]  <= take[k] ? (rem_s[k] - trial[k]) : rem_s[k];
			root_s[k+1] <= take[k] ? (root_s[k] | (64'd1 << (SQRT_N - 1 - k))) : root_s[k];
		end
		// near root only when h < 0 and |h| > root
		out_num.ray      <= side_f.ray;
		out_num.a        <= side_f.a;
		out_num.near_ok  <= side_f.ok && side_f.hneg && (side_f.hmag > root_f);
		out_num.far_ok   <= side_f.ok && (side_f.hneg || (root_f > side_f.hmag));
		out_num.near_num <= {1'b0, side_f.hmag} - {1'b0, root_f};
		out_num.far_num  <= side_f.hneg ? ({1'b0, side_f.hmag} + {1'b0, root_f})
		                                : ({1'b0, root_f} - {1'b0, side_f.hmag});
	end

endmodule

// ----- rtl/core/rpci_root.sv -----
// ----------------------------------------------------------------------------
// rpci_root
// One candidate root: distance divider, hit point, band test, azimuth CORDIC
// and wedge test.
// ----------------------------------------------------------------------------
module rpci_root import rpci_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic        in_ok,
	input  logic [64:0] in_num,
	input  logic [63:0] in_a,
	input  ray_t        in_ray,
	input  cfg_t        cfg,
	output logic        out_vld,
	output hit_t        out_hit,
	output ray_t        out_ray
);

	localparam int NW = 65 + FB;

	// divider stages
	logic             dv_s   [DIV_N+1];
	logic             dok_s  [DIV_N+1];
	logic             dbig_s [DIV_N+1];
	ray_t             dray_s [DIV_N+1];
	logic [63:0]      da_s   [DIV_N+1];
	logic [63:0]      drem_s [DIV_N+1];
	logic [DIV_N-1:0] dlo_s  [DIV_N+1];
	logic [DIV_N-1:0] dq_s   [DIV_N+1];
	logic [64:0]      rem2   [DIV_N];
	logic             dge    [DIV_N];
	logic [NW-1:0]    num_sh;

	// hit point stages
	logic v_s1, v_s2, v_s3, v_s4;
	logic ok_s1, ok_s2, ok_s3, ok_s4;
	logic [DIV_N-1:0] t_s1, t_s2, t_s3, t_s4;
	ray_t ray_s1, ray_s2, ray_s3, ray_s4;
	logic [31:0] dmag_s1 [3];
	logic dneg_s1 [3], dneg_s2 [3], dneg_s3 [3];
	logic signed [31:0] o_s1 [3], o_s2 [3], o_s3 [3];
	logic [63:0] plo_s2 [3];
	logic [62:0] phh_s2 [3];
	logic [40:0] q_s3 [3];
	logic ovf_s3 [3];
	logic signed [31:0] pt_s4 [3];
	logic [DIV_N-1:0] t_cap;
	logic signed [31:0] o_c [3], d_c [3];
	logic [94:0] psum [3];
	logic [94:0] pq [3];
	logic signed [42:0] ssum [3];

	// CORDIC stages
	logic               cv_s    [CORDIC_N+1];
	hit_t               chit_s  [CORDIC_N+1];
	ray_t               cray_s  [CORDIC_N+1];
	logic               cband_s [CORDIC_N+1];
	logic signed [CW-1:0] cu_s  [CORDIC_N+1];
	logic signed [CW-1:0] cw_s  [CORDIC_N+1];
	logic [31:0]        cacc_s  [CORDIC_N+1];
	logic signed [CW-1:0] x_ext, z_ext;
	logic [32:0]        phi_rnd;
	logic [AB-1:0]      phi;

	assign num_sh = {in_num, {FB{1'b0}}};

	always_comb begin
		for (int k = 0; k < DIV_N; k++) begin
			rem2[k] = {drem_s[k], dlo_s[k][DIV_N-1]};
			dge[k]  = rem2[k] >= {1'b0, da_s[k]};
		end
	end

	assign t_cap = (dbig_s[DIV_N] || (dq_s[DIV_N] > T_CAP)) ? T_CAP : dq_s[DIV_N];

	always_comb begin
		o_c[0] = dray_s[DIV_N].ox;
		o_c[1] = dray_s[DIV_N].oy;
		o_c[2] = dray_s[DIV_N].oz;
		d_c[0] = dray_s[DIV_N].dx;
		d_c[1] = dray_s[DIV_N].dy;
		d_c[2] = dray_s[DIV_N].dz;
		for (int c = 0; c < 3; c++) begin
			psum[c] = {31'd0, plo_s2[c]} + ({32'd0, phh_s2[c]} << 32);
			pq[c]   = psum[c] >> FB;
			ssum[c] = dneg_s3[c] ? ($signed({{11{o_s3[c][31]}}, o_s3[c]}) - $signed({2'b00, q_s3[c]}))
			                     : ($signed({{11{o_s3[c][31]}}, o_s3[c]}) + $signed({2'b00, q_s3[c]}));
		end
	end

	assign x_ext = {{(CW-32){pt_s4[0][31]}}, pt_s4[0]};
	assign z_ext = {{(CW-32){pt_s4[2][31]}}, pt_s4[2]};

	// round half up to AB bits and wrap into one turn
	assign phi_rnd = {1'b0, cacc_s[CORDIC_N]} + (33'd1 << (31 - AB));
	assign phi     = phi_rnd[31:32-AB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_N; k++) dv_s[k] <= 1'b0;
			for (int k = 0; k <= CORDIC_N; k++) cv_s[k] <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			dv_s[0] <= in_vld;
			for (int k = 0; k < DIV_N; k++) dv_s[k+1] <= dv_s[k];
			v_s1 <= dv_s[DIV_N];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			cv_s[0] <= v_s4;
			for (int k = 0; k < CORDIC_N; k++) cv_s[k+1] <= cv_s[k];
			out_vld <= cv_s[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		// divider: quotient fits DIV_N bits unless the top of the dividend reaches a
		dok_s[0]  <= in_ok;
		dray_s[0] <= in_ray;
		da_s[0]   <= in_a;
		drem_s[0] <= 64'(num_sh >> DIV_N);
		dlo_s[0]  <= num_sh[DIV_N-1:0];
		dbig_s[0] <= (num_sh >> DIV_N) >= NW'(in_a);
		dq_s[0]   <= '0;
		for (int k = 0; k < DIV_N; k++) begin
			dok_s[k+1]  <= dok_s[k];
			dray_s[k+1] <= dray_s[k];
			da_s[k+1]   <= da_s[k];
			dbig_s[k+1] <= dbig_s[k];
			drem_s[k+1] <= dge[k] ? 64'(rem2[k] - {1'b0, da_s[k]}) : rem2[k][63:0];
			dlo_s[k+1]  <= dlo_s[k] << 1;
			dq_s[k+1]   <= {dq_s[k][DIV_N-2:0], dge[k]};
		end
		// cap distance, drop roots at or below the minimum
		t_s1   <= t_cap;
		ok_s1  <= dok_s[DIV_N] && (t_cap > DIV_N'(cfg.min_dist));
		ray_s1 <= dray_s[DIV_N];
		for (int c = 0; c < 3; c++) begin
			o_s1[c]    <= o_c[c];
			dneg_s1[c] <= d_c[c][31];
			dmag_s1[c] <= d_c[c][31] ? 32'(-d_c[c]) : d_c[c];
		end
		// t * |d| in two partial products
		t_s2   <= t_s1;
		ok_s2  <= ok_s1;
		ray_s2 <= ray_s1;
		for (int c = 0; c < 3; c++) begin
			o_s2[c]    <= o_s1[c];
			dneg_s2[c] <= dneg_s1[c];
			plo_s2[c]  <= t_s1[31:0] * dmag_s1[c];
			phh_s2[c]  <= t_s1[62:32] * dmag_s1[c];
		end
		// offset and its overflow
		t_s3   <= t_s2;
		ok_s3  <= ok_s2;
		ray_s3 <= ray_s2;
		for (int c = 0; c < 3; c++) begin
			o_s3[c]    <= o_s2[c];
			dneg_s3[c] <= dneg_s2[c];
			q_s3[c]    <= pq[c][40:0];
			ovf_s3[c]  <= pq[c] > (95'd1 << 40);
		end
		// saturated hit point
		t_s4   <= t_s3;
		ok_s4  <= ok_s3;
		ray_s4 <= ray_s3;
		for (int c = 0; c < 3; c++) begin
			if (ovf_s3[c] || (ssum[c][42:31] != {12{ssum[c][31]}}))
				pt_s4[c] <= (ovf_s3[c] ? dneg_s3[c] : ssum[c][42]) ? 32'sh8000_0000 : 32'sh7fff_ffff;
			else
				pt_s4[c] <= ssum[c][31:0];
		end
		// band test and CORDIC entry (fold z < 0 by half a turn)
		chit_s[0].ok <= ok_s4;
		chit_s[0].t  <= t_s4;
		chit_s[0].px <= pt_s4[0];
		chit_s[0].py <= pt_s4[1];
		chit_s[0].pz <= pt_s4[2];
		cray_s[0]    <= ray_s4;
		cband_s[0]   <= (pt_s4[1] > cfg.bottom_y) && (pt_s4[1] < cfg.top_y);
		cu_s[0]      <= pt_s4[2][31] ? -z_ext : z_ext;
		cw_s[0]      <= pt_s4[2][31] ? -x_ext : x_ext;
		cacc_s[0]    <= pt_s4[2][31] ? 32'h8000_0000 : 32'h0000_0000;
		for (int k = 0; k < CORDIC_N; k++) begin
			chit_s[k+1]  <= chit_s[k];
			cray_s[k+1]  <= cray_s[k];
			cband_s[k+1] <= cband_s[k];
			if (cw_s[k] > 0) begin
				cu_s[k+1]   <= cu_s[k] + (cw_s[k] >>> k);
				cw_s[k+1]   <= cw_s[k] - (cu_s[k] >>> k);
				cacc_s[k+1] <= cacc_s[k] + turn_atan(k);
			end else begin
				cu_s[k+1]   <= cu_s[k] - (cw_s[k] >>> k);
				cw_s[k+1]   <= cw_s[k] + (cu_s[k] >>> k);
				cacc_s[k+1] <= cacc_s[k] - turn_atan(k);
			end
		end
		// wedge test
		out_hit.t  <= chit_s[CORDIC_N].t;
		out_hit.px <= chit_s[CORDIC_N].px;
		out_hit.py <= chit_s[CORDIC_N].py;
		out_hit.pz <= chit_s[CORDIC_N].pz;
		out_hit.ok <= chit_s[CORDIC_N].ok && cband_s[CORDIC_N]
		              && ({1'b0, phi} >= cfg.angle_min) && ({1'b0, phi} <= cfg.angle_max);
		out_ray    <= cray_s[CORDIC_N];
	end

endmodule

// ----- rtl/core/rpci_normal.sv -----
// ----------------------------------------------------------------------------
// rpci_normal
// Unit normal by radius division, orientation flip toward the ray, and the
// final result register.
// ----------------------------------------------------------------------------
module rpci_normal import rpci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  hit_t               in_hit,
	input  logic signed [31:0] in_dx,
	input  logic signed [31:0] in_dz,
	input  logic [30:0]        radius,
	output logic               out_vld,
	output logic               is_hit,
	output logic [30:0]        distance,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_z,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);

	logic               nv_s   [NDIV_N+1];
	hit_t               nhit_s [NDIV_N+1];
	logic signed [31:0] nd_s   [NDIV_N+1][2];
	logic [30:0]        nrem_s [NDIV_N+1][2];
	logic [NDIV_N-1:0]  nlo_s  [NDIV_N+1][2];
	logic [NDIV_N-1:0]  nq_s   [NDIV_N+1][2];
	logic               nbig_s [NDIV_N+1][2];
	logic               nneg_s [NDIV_N+1][2];
	logic [31:0]        nr2    [NDIV_N][2];
	logic               nge    [NDIV_N][2];
	logic signed [31:0] pv [2];
	logic [31:0]        pm [2];

	logic v_s1, v_s2;
	hit_t hit_s1, hit_s2;
	logic signed [31:0] d_s1 [2];
	logic signed [15:0] n_s1 [2], n_s2 [2];
	logic signed [47:0] prod_s2 [2];
	logic signed [48:0] dot;
	logic signed [15:0] nf [2];

	always_comb begin
		pv[0] = in_hit.px;
		pv[1] = in_hit.pz;
		for (int c = 0; c < 2; c++) pm[c] = pv[c][31] ? 32'(-pv[c]) : pv[c];
		for (int k = 0; k < NDIV_N; k++) begin
			for (int c = 0; c < 2; c++) begin
				nr2[k][c] = {nrem_s[k][c], nlo_s[k][c][NDIV_N-1]};
				nge[k][c] = nr2[k][c] >= {1'b0, radius};
			end
		end
		dot = prod_s2[0] + prod_s2[1];
		for (int c = 0; c < 2; c++)
			nf[c] = (n_s2[c] == -16'sd32768) ? 16'sd32767 : -n_s2[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NDIV_N; k++) nv_s[k] <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			nv_s[0] <= in_vld;
			for (int k = 0; k < NDIV_N; k++) nv_s[k+1] <= nv_s[k];
			v_s1    <= nv_s[NDIV_N];
			v_s2    <= v_s1;
			out_vld <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// |p| * 2^15 / r, quotient limited to NDIV_N bits
		nhit_s[0]   <= in_hit;
		nd_s[0][0]  <= in_dx;
		nd_s[0][1]  <= in_dz;
		for (int c = 0; c < 2; c++) begin
			nrem_s[0][c] <= pm[c][31:1];
			nlo_s[0][c]  <= {pm[c][0], 15'd0};
			nbig_s[0][c] <= pm[c][31:1] >= radius;
			nneg_s[0][c] <= pv[c][31];
			nq_s[0][c]   <= '0;
		end
		for (int k = 0; k < NDIV_N; k++) begin
			nhit_s[k+1] <= nhit_s[k];
			for (int c = 0; c < 2; c++) begin
				nd_s[k+1][c]   <= nd_s[k][c];
				nbig_s[k+1][c] <= nbig_s[k][c];
				nneg_s[k+1][c] <= nneg_s[k][c];
				nrem_s[k+1][c] <= nge[k][c] ? 31'(nr2[k][c] - {1'b0, radius}) : nr2[k][c][30:0];
				nlo_s[k+1][c]  <= nlo_s[k][c] << 1;
				nq_s[k+1][c]   <= {nq_s[k][c][NDIV_N-2:0], nge[k][c]};
			end
		end
		// saturate to Q1.15
		hit_s1 <= nhit_s[NDIV_N];
		for (int c = 0; c < 2; c++) begin
			d_s1[c] <= nd_s[NDIV_N][c];
			if (nneg_s[NDIV_N][c])
				n_s1[c] <= (nbig_s[NDIV_N][c] || (nq_s[NDIV_N][c] > 16'd32768))
				           ? -16'sd32768 : $signed(16'(~nq_s[NDIV_N][c] + 16'd1));
			else
				n_s1[c] <= (nbig_s[NDIV_N][c] || (nq_s[NDIV_N][c] > 16'd32767))
				           ? 16'sd32767 : $signed(nq_s[NDIV_N][c]);
		end
		// facing test products
		hit_s2 <= hit_s1;
		for (int c = 0; c < 2; c++) begin
			n_s2[c]    <= n_s1[c];
			prod_s2[c] <= d_s1[c] * n_s1[c];
		end
		// flip toward the ray; a miss reads all zero
		is_hit   <= hit_s2.ok;
		distance <= !hit_s2.ok ? 31'd0
		            : ((hit_s2.t > DIV_N'(31'h7fff_ffff)) ? 31'h7fff_ffff : hit_s2.t[30:0]);
		normal_x <= !hit_s2.ok ? 16'sd0 : ((dot > 0) ? nf[0] : n_s2[0]);
		normal_z <= !hit_s2.ok ? 16'sd0 : ((dot > 0) ? nf[1] : n_s2[1]);
		point_x  <= hit_s2.ok ? hit_s2.px : 32'sd0;
		point_y  <= hit_s2.ok ? hit_s2.py : 32'sd0;
		point_z  <= hit_s2.ok ? hit_s2.pz : 32'sd0;
	end

endmodule
